FILE: rtl/core/sti_pkg.sv
// Shared types and status codes for the sorted key/value table.
package sti_pkg;

    typedef logic [2:0] status_t;

    localparam status_t ST_INSERTED  = 3'd0;
    localparam status_t ST_DUPLICATE = 3'd1;
    localparam status_t ST_FULL      = 3'd2;
    localparam status_t ST_REMOVED   = 3'd3;
    localparam status_t ST_NOT_FOUND = 3'd4;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 9;
    localparam int OCC_W = 9;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

endpackage

FILE: rtl/core/sti_if.sv
// Request, response and configuration channel interfaces for the sorted table.
interface sti_req_if
    import sti_pkg::*;
    ();
    logic                    valid;
    logic                    ready;
    logic                    action;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output action, output key, output value, input ready);
    modport sink   (input valid, input action, input key, input value, output ready);
endinterface

interface sti_rsp_if
    import sti_pkg::*;
    ();
    logic                    valid;
    logic                    ready;
    status_t                 status;
    logic signed [KEY_W-1:0] removed_key;
    logic signed [VAL_W-1:0] removed_value;
    logic [OCC_W-1:0]        occupancy;

    modport source (output valid, output status, output removed_key, output removed_value,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input removed_key, input removed_value,
                    input occupancy, output ready);
endinterface

interface sti_cfg_if
    import sti_pkg::*;
    ();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

FILE: rtl/core/sorted_table_insert_remove_top.sv
// Key/value table: binary search on insert and remove over one record memory; an insert that misses appends at the end.
// Table full, or remove from an empty table, goes straight to S_OUT; otherwise each search probe
// reads a record in S_SEARCH and compares it in S_CMP. A remove that hits then shifts later
// records down one slot in S_SHIFT before the response is loaded in S_OUT.
// One request at a time; the read port and write port of the record memory set the pace.
// Reset clears the record count and sets capacity to 256; memory contents are not cleared.
module sorted_table_insert_remove_top
    import sti_pkg::*;
#(
    parameter int DEPTH = 256
)(
    input  logic      clk,
    input  logic      rst_n,
    sti_req_if.sink   req,
    sti_rsp_if.source rsp,
    sti_cfg_if.sink   cfg
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > CAP_W) ? CW : CAP_W;
    localparam int RW = KEY_W + VAL_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CAP_W-1:0]        cap_reg;
    logic                    act_reg, act_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic [CW-1:0]           lo_reg, lo_next;
    logic [CW-1:0]           hi1_reg, hi1_next;
    logic [AW-1:0]           mid_reg, mid_next;
    logic [CW-1:0]           sp_reg, sp_next;
    logic [AW-1:0]           wr_addr_reg, wr_addr_next;
    logic                    rd_pend_reg, rd_pend_next;
    status_t                 status_reg, status_next;
    logic signed [KEY_W-1:0] rk_reg, rk_next;
    logic signed [VAL_W-1:0] rv_reg, rv_next;

    logic                    out_valid_reg, out_valid_next;
    status_t                 out_status_reg, out_status_next;
    logic signed [KEY_W-1:0] out_rk_reg, out_rk_next;
    logic signed [VAL_W-1:0] out_rv_reg, out_rv_next;
    logic [OCC_W-1:0]        out_occ_reg, out_occ_next;

    logic [RW-1:0]           mem [DEPTH];
    logic                    mem_we, mem_re;
    logic [AW-1:0]           mem_waddr, mem_raddr;
    logic [RW-1:0]           mem_wdata;
    logic [RW-1:0]           rd_data_reg;

    logic [CW:0]             mid_sum;
    logic [CW-1:0]           mid_ext;
    logic [AW-1:0]           mid_now;
    logic signed [KEY_W-1:0] rd_key;
    logic signed [VAL_W-1:0] rd_val;
    logic                    full;
    logic [CW+OCC_W-1:0]     occ_wide;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.removed_key   = out_rk_reg;
    assign rsp.removed_value = out_rv_reg;
    assign rsp.occupancy     = out_occ_reg;

    // floor((lo + hi) / 2) with hi kept as an exclusive bound
    assign mid_sum = (CW+1)'(lo_reg) + (CW+1)'(hi1_reg) - (CW+1)'(1);
    assign mid_now = mid_sum[AW:1];
    assign mid_ext = CW'(mid_reg);

    assign rd_key = rd_data_reg[RW-1:VAL_W];
    assign rd_val = rd_data_reg[VAL_W-1:0];

    assign full = (XW'(count_reg) >= XW'(cap_reg)) || (count_reg >= CW'(DEPTH));
    assign occ_wide = (CW+OCC_W)'(count_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        act_next        = act_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        lo_next         = lo_reg;
        hi1_next        = hi1_reg;
        mid_next        = mid_reg;
        sp_next         = sp_reg;
        wr_addr_next    = wr_addr_reg;
        rd_pend_next    = rd_pend_reg;
        status_next     = status_reg;
        rk_next         = rk_reg;
        rv_next         = rv_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_rk_next     = out_rk_reg;
        out_rv_next     = out_rv_reg;
        out_occ_next    = out_occ_reg;
        mem_we          = 1'b0;
        mem_waddr       = wr_addr_reg;
        mem_wdata       = rd_data_reg;
        mem_re          = 1'b0;
        mem_raddr       = mid_now;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    act_next = req.action;
                    key_next = req.key;
                    val_next = req.value;
                    rk_next  = '0;
                    rv_next  = '0;
                    lo_next  = '0;
                    hi1_next = count_reg;
                    if (req.action == ACT_INSERT && full)
                    begin
                        status_next = ST_FULL;
                        state_next  = S_OUT;
                    end
                    else if (req.action == ACT_REMOVE && count_reg == '0)
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                if (lo_reg < hi1_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = mid_now;
                    mid_next   = mid_now;
                    state_next = S_CMP;
                end
                else if (act_reg == ACT_INSERT)
                begin
                    // miss: append at the end
                    mem_we      = 1'b1;
                    mem_waddr   = count_reg[AW-1:0];
                    mem_wdata   = {key_reg, val_reg};
                    count_next  = count_reg + CW'(1);
                    status_next = ST_INSERTED;
                    state_next  = S_OUT;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_OUT;
                end
            end
            S_CMP:
            begin
                if (rd_key == key_reg)
                begin
                    if (act_reg == ACT_INSERT)
                    begin
                        status_next = ST_DUPLICATE;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        rk_next      = rd_key;
                        rv_next      = rd_val;
                        wr_addr_next = mid_reg;
                        sp_next      = mid_ext + CW'(1);
                        rd_pend_next = 1'b0;
                        state_next   = S_SHIFT;
                    end
                end
                else if (rd_key < key_reg)
                begin
                    lo_next    = mid_ext + CW'(1);
                    state_next = S_SEARCH;
                end
                else
                begin
                    hi1_next   = mid_ext;
                    state_next = S_SEARCH;
                end
            end
            S_SHIFT:
            begin
                // read entry sp while writing the entry read last cycle one slot down
                if (rd_pend_reg)
                begin
                    mem_we       = 1'b1;
                    mem_waddr    = wr_addr_reg;
                    mem_wdata    = rd_data_reg;
                    wr_addr_next = wr_addr_reg + AW'(1);
                end
                if (sp_reg < count_reg)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = sp_reg[AW-1:0];
                    sp_next      = sp_reg + CW'(1);
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                    if (!rd_pend_reg)
                    begin
                        count_next  = count_reg - CW'(1);
                        status_next = ST_REMOVED;
                        state_next  = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_rk_next     = rk_reg;
                    out_rv_next     = rv_reg;
                    out_occ_next    = occ_wide[OCC_W-1:0];
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            cap_reg        <= CAP_RESET;
            act_reg        <= ACT_INSERT;
            key_reg        <= '0;
            val_reg        <= '0;
            lo_reg         <= '0;
            hi1_reg        <= '0;
            mid_reg        <= '0;
            sp_reg         <= '0;
            wr_addr_reg    <= '0;
            rd_pend_reg    <= 1'b0;
            status_reg     <= ST_INSERTED;
            rk_reg         <= '0;
            rv_reg         <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_INSERTED;
            out_rk_reg     <= '0;
            out_rv_reg     <= '0;
            out_occ_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            if (cfg.valid)
            begin
                cap_reg <= cfg.capacity;
            end
            act_reg        <= act_next;
            key_reg        <= key_next;
            val_reg        <= val_next;
            lo_reg         <= lo_next;
            hi1_reg        <= hi1_next;
            mid_reg        <= mid_next;
            sp_reg         <= sp_next;
            wr_addr_reg    <= wr_addr_next;
            rd_pend_reg    <= rd_pend_next;
            status_reg     <= status_next;
            rk_reg         <= rk_next;
            rv_reg         <= rv_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_rk_reg     <= out_rk_next;
            out_rv_reg     <= out_rv_next;
            out_occ_reg    <= out_occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("record count above depth");

    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (hi1_reg <= count_reg))
        else $error("search bound beyond stored records");

    a_shift_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && mem_we) |-> (CW'(wr_addr_reg) + CW'(1) < count_reg))
        else $error("shift writes past the last record");

    a_insert_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && act_reg == ACT_INSERT) |->
        (status_reg == ST_INSERTED || status_reg == ST_DUPLICATE || status_reg == ST_FULL))
        else $error("remove status on an insert request");

endmodule

FILE: test/sti_table_checker.sv
// Checker for the sorted table: mirrors the table, predicts every response and compares it.
`timescale 1ns / 1ps

module sti_table_checker
    import sti_pkg::*;
#(
    parameter int DEPTH = 256
)(
    input  logic clk,
    input  logic rst_n,
    sti_req_if   req,
    sti_rsp_if   rsp,
    sti_cfg_if   cfg,
    output int   error_count,
    output int   pending
);

    typedef struct {
        status_t                 status;
        logic signed [KEY_W-1:0] rkey;
        logic signed [VAL_W-1:0] rval;
        logic [OCC_W-1:0]        occ;
    } table_result_t;

    logic signed [KEY_W-1:0] key_mem [DEPTH];
    logic signed [VAL_W-1:0] val_mem [DEPTH];
    int                      entry_count;
    logic [CAP_W-1:0]        cap_reg;
    table_result_t           awaited_results[$];

    // Standard binary search over the stored entries, keys compared as signed.
    function automatic bit locate_key(input logic signed [KEY_W-1:0] probe, output int hit_at);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = entry_count - 1;
        hit_at = 0;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if (key_mem[mid] == probe)
            begin
                hit_at = mid;
                return 1'b1;
            end
            if (key_mem[mid] < probe)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return 1'b0;
    endfunction

    function automatic table_result_t apply_request(input logic                    act,
                                                    input logic signed [KEY_W-1:0] k,
                                                    input logic signed [VAL_W-1:0] v);
        table_result_t r;
        int            at;
        int            eff_cap;
        int            i;
        r.status = ST_NOT_FOUND;
        r.rkey   = '0;
        r.rval   = '0;
        eff_cap  = (int'(cap_reg) < DEPTH) ? int'(cap_reg) : DEPTH;
        if (act == ACT_INSERT)
        begin
            // table full wins over a duplicate key
            if (entry_count >= eff_cap)
                r.status = ST_FULL;
            else if (locate_key(k, at))
                r.status = ST_DUPLICATE;
            else
            begin
                key_mem[entry_count] = k;
                val_mem[entry_count] = v;
                entry_count++;
                r.status = ST_INSERTED;
            end
        end
        else if (entry_count != 0 && locate_key(k, at))
        begin
            r.rkey = key_mem[at];
            r.rval = val_mem[at];
            for (i = at; i + 1 < entry_count; i++)
            begin
                key_mem[i] = key_mem[i + 1];
                val_mem[i] = val_mem[i + 1];
            end
            entry_count--;
            r.status = ST_REMOVED;
        end
        r.occ = entry_count[OCC_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        table_result_t want;
        if (!rst_n)
        begin
            entry_count = 0;
            cap_reg     = CAP_RESET;
            awaited_results.delete();
            error_count = 0;
            pending     = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    if (error_count < 10)
                        $display("%0t: response transfer with no request outstanding: status %0d",
                                 $realtime, rsp.status);
                    error_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (rsp.status !== want.status || rsp.removed_key !== want.rkey ||
                        rsp.removed_value !== want.rval || rsp.occupancy !== want.occ)
                    begin
                        if (error_count < 10)
                            $display("%0t: mismatch: expected st %0d key %h val %h occ %0d, got st %0d key %h val %h occ %0d",
                                     $realtime, want.status, want.rkey, want.rval, want.occ,
                                     rsp.status, rsp.removed_key, rsp.removed_value,
                                     rsp.occupancy);
                        error_count++;
                    end
                end
            end
            if (cfg.valid && cfg.ready)
                cap_reg = cfg.capacity;
            if (req.valid && req.ready)
                awaited_results.push_back(apply_request(req.action, req.key, req.value));
            pending = awaited_results.size();
        end
    end

endmodule

FILE: test/tb_sorted_table_insert_remove_top.sv
// Testbench top for the sorted table: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_sorted_table_insert_remove_top;
    import sti_pkg::*;

    localparam int DEPTH          = 256;
    localparam int IDLE_PCT       = 13;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT = 5000;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   stall_cycles = 0;
    bit   steady;
    bit   hold_rsp;
    bit   hold_done;
    longint key_cursor;
    logic signed [KEY_W-1:0] sent_keys[$];

    sti_req_if req_ch ();
    sti_rsp_if rsp_ch ();
    sti_cfg_if cfg_ch ();

    sorted_table_insert_remove_top #(.DEPTH(DEPTH)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    sti_table_checker #(.DEPTH(DEPTH)) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg         (cfg_ch),
        .error_count (errors),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Response side: random back-pressure, a steady stretch, and one long hold-off.
    initial
    begin
        rsp_ch.ready = 1'b0;
        hold_done    = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_rsp && !hold_done)
            begin
                rsp_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (steady)
                rsp_ch.ready = 1'b1;
            else
                rsp_ch.ready = ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // End the run when nothing has moved on any channel for too long.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_request(input logic                    act,
                                input logic signed [KEY_W-1:0] k,
                                input logic signed [VAL_W-1:0] v);
        @(negedge clk);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid  = 1'b1;
        req_ch.action = act;
        req_ch.key    = k;
        req_ch.value  = v;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Drop valid, wait for every outstanding response, then let the block go quiet.
    task automatic settle(input int quiet_cycles);
        @(negedge clk);
        req_ch.valid = 1'b0;
        wait (pending == 0);
        repeat (quiet_cycles) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        settle(8);
        cfg_ch.valid    = 1'b1;
        cfg_ch.capacity = cap;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Mostly ascending inserts and removes of stored keys; some random keys,
    // duplicates and misses as noise. The table is drained at the end.
    task automatic run_phase(input int n_items, input int insert_pct);
        int r;
        int idx;
        logic signed [KEY_W-1:0] k;
        key_cursor = longint'($urandom_range(0, 3 << 30)) - 64'sd2147483648;
        for (int n = 0; n < n_items; n++)
        begin
            if (n % 200 == 199)
                settle(0);
            r = $urandom_range(99);
            if (r < 8)
            begin
                k = $urandom;
                sent_keys.push_back(k);
                send_request(ACT_INSERT, k, $urandom);
            end
            else if (r < 12 && sent_keys.size() != 0)
                send_request(ACT_INSERT, sent_keys[$urandom_range(sent_keys.size() - 1)],
                             $urandom);
            else if (r < 16)
                send_request(ACT_REMOVE, $urandom, $urandom);
            else if (sent_keys.size() == 0 || $urandom_range(99) < insert_pct)
            begin
                key_cursor += longint'($urandom_range(1, 1 << 22));
                if (key_cursor > 64'sd2147483647)
                    key_cursor = 64'sd2147483647;
                k = key_cursor[KEY_W-1:0];
                sent_keys.push_back(k);
                send_request(ACT_INSERT, k, $urandom);
            end
            else
            begin
                idx = $urandom_range(sent_keys.size() - 1);
                k = sent_keys[idx];
                sent_keys.delete(idx);
                send_request(ACT_REMOVE, k, $urandom);
            end
        end
        while (sent_keys.size() != 0)
        begin
            idx = $urandom_range(sent_keys.size() - 1);
            k = sent_keys[idx];
            sent_keys.delete(idx);
            send_request(ACT_REMOVE, k, $urandom);
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        steady          = 1'b0;
        hold_rsp        = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.action   = ACT_INSERT;
        req_ch.key      = '0;
        req_ch.value    = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.capacity = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // extremes of key and value, duplicates, removes from front, middle and end
        send_request(ACT_REMOVE, 32'sh0000_0000, 32'sh0000_0000);
        send_request(ACT_INSERT, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_request(ACT_INSERT, 32'shFFFF_FFFF, 32'sh8000_0000);
        send_request(ACT_INSERT, 32'sh0000_0000, 32'shFFFF_FFFF);
        send_request(ACT_INSERT, 32'sh7FFF_FFFF, 32'sh0000_0000);
        send_request(ACT_INSERT, 32'sh0000_0000, 32'sh1234_5678);
        send_request(ACT_INSERT, 32'sh8000_0000, 32'sh0000_0001);
        send_request(ACT_REMOVE, 32'sh0000_0005, 32'shFFFF_FFFF);
        send_request(ACT_REMOVE, 32'shFFFF_FFFF, 32'sh0000_0000);
        send_request(ACT_REMOVE, 32'sh7FFF_FFFF, 32'sh0000_0000);
        send_request(ACT_REMOVE, 32'sh8000_0000, 32'sh0000_0000);
        send_request(ACT_REMOVE, 32'sh0000_0000, 32'sh0000_0000);
        send_request(ACT_REMOVE, 32'sh0000_0000, 32'sh0000_0000);

        // zero capacity rejects every insert
        write_capacity(9'd0);
        send_request(ACT_INSERT, 32'sh0000_0001, 32'sh0000_0001);
        send_request(ACT_REMOVE, 32'sh0000_0001, 32'sh0000_0000);

        // full is reported before a duplicate check
        write_capacity(9'd2);
        send_request(ACT_INSERT, 32'sh0000_000A, 32'sh0000_0001);
        send_request(ACT_INSERT, 32'sh0000_0014, 32'sh0000_0002);
        send_request(ACT_INSERT, 32'sh0000_001E, 32'sh0000_0003);
        send_request(ACT_INSERT, 32'sh0000_000A, 32'sh0000_0004);

        // capacity above depth, and an out-of-order key that the search then misses
        write_capacity(9'd511);
        send_request(ACT_INSERT, 32'sh0000_0005, 32'sh0000_0005);
        send_request(ACT_REMOVE, 32'sh0000_0005, 32'sh0000_0000);
        send_request(ACT_REMOVE, 32'sh0000_0014, 32'sh0000_0000);
        send_request(ACT_REMOVE, 32'sh0000_000A, 32'sh0000_0000);
        send_request(ACT_REMOVE, 32'sh0000_0005, 32'sh0000_0000);

        write_capacity(9'd256);
        run_phase(450, 85);

        write_capacity(9'd3);
        run_phase(150, 60);

        write_capacity(9'd0);
        run_phase(40, 60);

        write_capacity(9'd1);
        run_phase(80, 60);

        // long response hold-off while requests keep coming
        write_capacity(9'd511);
        hold_rsp = 1'b1;
        run_phase(250, 65);

        write_capacity(9'd100);
        steady = 1'b1;
        run_phase(200, 70);
        steady = 1'b0;

        settle(DRAIN_CYCLES);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/sti_pkg.sv
rtl/core/sti_if.sv
rtl/core/sorted_table_insert_remove_top.sv
test/sti_table_checker.sv
test/tb_sorted_table_insert_remove_top.sv
